FILE: rtl/rhp_pkg.sv
// Package for the RTP header parser: widths, item codes, status codes and the
// command record passed from the parse front end to the output back end.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rhp_pkg;

	// Byte offset counter width, saturating at its maximum
	localparam int OFFSET_BITS = 19;
	// Header length register width
	localparam int HLEN_BITS = 19;
	// Compare width that holds offset + 1 and the header length
	localparam int CMP_BITS = ((OFFSET_BITS > HLEN_BITS) ? OFFSET_BITS : HLEN_BITS) + 1;

	// Fixed header size in bytes and the number of stored bytes (1 to 11)
	localparam int FIXED_HDR_BYTES = 12;
	localparam int STORED_BYTES = FIXED_HDR_BYTES - 1;
	localparam int STORE_IDX_BITS = $clog2(STORED_BYTES);

	// Expected RTP version
	localparam logic [1:0] RTP_VERSION = 2'd2;

	// Command queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		KIND_HEADER  = 2'd0,
		KIND_PAYLOAD = 2'd1,
		KIND_END     = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		STATUS_OK          = 2'd0,
		STATUS_SHORT       = 2'd1,
		STATUS_BAD_VERSION = 2'd2,
		STATUS_TRUNCATED   = 2'd3
	} status_t;

	// One classified byte: which results it causes and their contents
	typedef struct packed {
		logic        emit_header;
		logic        emit_payload;
		logic        emit_end;
		status_t     status;
		logic        marker_bit;
		logic [6:0]  payload_type;
		logic [15:0] sequence_number;
		logic [31:0] time_stamp;
		logic [31:0] source_id;
		logic [7:0]  payload_value;
	} cmd_t;

endpackage

`default_nettype wire

FILE: rtl/rhp_front.sv
// Parse front end: accepts datagram bytes, tracks the header layout and
// classifies each byte into a command for the queue. Depends on rhp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rhp_front (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        byte_valid,
	output logic             byte_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        end_of_datagram,
	input  wire logic        queue_full,
	output logic             push,
	output rhp_pkg::cmd_t    cmd
);
	import rhp_pkg::*;

	logic [OFFSET_BITS-1:0] byte_offset_q;
	logic [HLEN_BITS-1:0]   header_length_q;
	logic [3:0]             csrc_count_q;
	logic                   ext_present_q;
	logic [7:0]             ext_words_high_q;
	logic                   version_bad_q;
	logic                   header_done_q;
	logic [7:0]             fixed_bytes_q [STORED_BYTES];

	logic                   fire;
	logic [HLEN_BITS-1:0]   hlen_n;
	logic [3:0]             csrc_n;
	logic                   ext_n;
	logic [7:0]             ewh_n;
	logic                   vbad_n;
	logic                   hit;
	logic                   done_n;
	logic [6:0]             ext_base;
	logic [7:0]             byte11;
	logic                   store_en;
	logic [STORE_IDX_BITS-1:0] store_idx;

	assign byte_stall = queue_full;
	assign fire = byte_valid && !byte_stall;

	always_comb begin
		hlen_n = header_length_q;
		csrc_n = csrc_count_q;
		ext_n = ext_present_q;
		ewh_n = ext_words_high_q;
		vbad_n = version_bad_q;
		hit = 1'b0;
		ext_base = 7'(FIXED_HDR_BYTES) + {1'b0, csrc_n, 2'b00};
		if (!header_done_q) begin
			if (byte_offset_q == '0) begin
				vbad_n = (data_byte[7:6] != RTP_VERSION);
				csrc_n = data_byte[3:0];
				ext_n = data_byte[4];
				hlen_n = HLEN_BITS'(FIXED_HDR_BYTES) + HLEN_BITS'({data_byte[3:0], 2'b00})
					+ (data_byte[4] ? HLEN_BITS'(4) : '0);
				ext_base = 7'(FIXED_HDR_BYTES) + {1'b0, data_byte[3:0], 2'b00};
			end
			if (ext_n) begin
				if (byte_offset_q == OFFSET_BITS'(ext_base + 7'd2)) begin
					ewh_n = data_byte;
				end else if (byte_offset_q == OFFSET_BITS'(ext_base + 7'd3)) begin
					hlen_n = header_length_q
						+ HLEN_BITS'({ext_words_high_q, data_byte, 2'b00});
				end
			end
			hit = !vbad_n && (CMP_BITS'(byte_offset_q) + CMP_BITS'(1) == CMP_BITS'(hlen_n));
		end
		done_n = header_done_q || hit;
	end

	// Bytes 1 to 11 go to the store; byte 11 may be needed in its own cycle
	assign store_en = !header_done_q && (byte_offset_q != '0)
		&& (byte_offset_q <= OFFSET_BITS'(STORED_BYTES));
	assign store_idx = STORE_IDX_BITS'(byte_offset_q - OFFSET_BITS'(1));
	assign byte11 = (byte_offset_q == OFFSET_BITS'(STORED_BYTES)) ? data_byte
		: fixed_bytes_q[STORED_BYTES-1];

	always_comb begin
		cmd = '0;
		cmd.emit_header = hit;
		cmd.emit_payload = header_done_q;
		cmd.emit_end = end_of_datagram;
		if (done_n) begin
			cmd.status = STATUS_OK;
		end else if (byte_offset_q < OFFSET_BITS'(STORED_BYTES)) begin
			cmd.status = STATUS_SHORT;
		end else if (vbad_n) begin
			cmd.status = STATUS_BAD_VERSION;
		end else begin
			cmd.status = STATUS_TRUNCATED;
		end
		cmd.marker_bit = fixed_bytes_q[0][7];
		cmd.payload_type = fixed_bytes_q[0][6:0];
		cmd.sequence_number = {fixed_bytes_q[1], fixed_bytes_q[2]};
		cmd.time_stamp = {fixed_bytes_q[3], fixed_bytes_q[4], fixed_bytes_q[5],
			fixed_bytes_q[6]};
		cmd.source_id = {fixed_bytes_q[7], fixed_bytes_q[8], fixed_bytes_q[9], byte11};
		cmd.payload_value = data_byte;
	end

	assign push = fire && (cmd.emit_header || cmd.emit_payload || cmd.emit_end);

	always_ff @(posedge clk) begin
		if (fire && store_en) begin
			fixed_bytes_q[store_idx] <= data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_offset_q <= '0;
			header_length_q <= HLEN_BITS'(FIXED_HDR_BYTES);
			csrc_count_q <= '0;
			ext_present_q <= 1'b0;
			ext_words_high_q <= '0;
			version_bad_q <= 1'b0;
			header_done_q <= 1'b0;
		end else if (fire) begin
			if (end_of_datagram) begin
				byte_offset_q <= '0;
				header_length_q <= HLEN_BITS'(FIXED_HDR_BYTES);
				csrc_count_q <= '0;
				ext_present_q <= 1'b0;
				ext_words_high_q <= '0;
				version_bad_q <= 1'b0;
				header_done_q <= 1'b0;
			end else begin
				if (byte_offset_q != '1) begin
					byte_offset_q <= byte_offset_q + OFFSET_BITS'(1);
				end
				header_length_q <= hlen_n;
				csrc_count_q <= csrc_n;
				ext_present_q <= ext_n;
				ext_words_high_q <= ewh_n;
				version_bad_q <= vbad_n;
				header_done_q <= done_n;
			end
		end
	end

	a_done_needs_good_version: assert property (@(posedge clk) disable iff (!arst_n)
		header_done_q |-> !version_bad_q)
		else $error("header done with bad version");

	a_payload_only_after_header: assert property (@(posedge clk) disable iff (!arst_n)
		(push && cmd.emit_payload) |-> !cmd.emit_header)
		else $error("payload and header from one byte");

	a_end_always_pushed: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && end_of_datagram) |-> push)
		else $error("end of datagram without command");

endmodule

`default_nettype wire

FILE: rtl/rhp_queue.sv
// Short command queue between parse front end and output back end.
// Register array with one read port. Depends on rhp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rhp_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  rhp_pkg::cmd_t      cmd_in,
	output logic               full,
	output logic               valid,
	output rhp_pkg::cmd_t      cmd_out,
	input  wire logic          pop
);
	import rhp_pkg::*;

	cmd_t                 entry_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QCNT_BITS-1:0] count_q;

	assign full = (count_q == QCNT_BITS'(QUEUE_DEPTH));
	assign valid = (count_q != '0);
	assign cmd_out = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_BITS'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_BITS'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_BITS'(1);
			end
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> valid)
		else $error("pop from empty queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_BITS'(QUEUE_DEPTH))
		else $error("queue count out of range");

endmodule

`default_nettype wire

FILE: rtl/rhp_back.sv
// Output back end: expands each queued command into one or two result
// transactions and holds them in the output register. Depends on rhp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rhp_back (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cmd_valid,
	input  rhp_pkg::cmd_t    cmd,
	output logic             cmd_pop,
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic [1:0]       kind,
	output logic             marker_bit,
	output logic [6:0]       payload_type,
	output logic [15:0]      sequence_number,
	output logic [31:0]      time_stamp,
	output logic [31:0]      source_id,
	output logic [7:0]       payload_value,
	output logic [1:0]       status,
	output logic             last_of_run
);
	import rhp_pkg::*;

	logic        second_q;
	logic        valid_q;
	kind_t       kind_q;
	logic        marker_q;
	logic [6:0]  ptype_q;
	logic [15:0] seq_q;
	logic [31:0] ts_q;
	logic [31:0] ssrc_q;
	logic [7:0]  payload_q;
	status_t     status_q;
	logic        last_q;

	logic        load;
	logic        two_items;
	logic        item_last;
	kind_t       item_kind;

	assign load = cmd_valid && (!valid_q || !result_stall);
	assign two_items = cmd.emit_end && (cmd.emit_header || cmd.emit_payload);
	assign item_last = second_q || !two_items;
	assign cmd_pop = load && item_last;

	always_comb begin
		if (second_q || (!cmd.emit_header && !cmd.emit_payload)) begin
			item_kind = KIND_END;
		end else if (cmd.emit_header) begin
			item_kind = KIND_HEADER;
		end else begin
			item_kind = KIND_PAYLOAD;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= item_kind;
			last_q <= item_last;
			marker_q <= 1'b0;
			ptype_q <= '0;
			seq_q <= '0;
			ts_q <= '0;
			ssrc_q <= '0;
			payload_q <= '0;
			status_q <= STATUS_OK;
			unique case (item_kind)
				KIND_HEADER: begin
					marker_q <= cmd.marker_bit;
					ptype_q <= cmd.payload_type;
					seq_q <= cmd.sequence_number;
					ts_q <= cmd.time_stamp;
					ssrc_q <= cmd.source_id;
				end
				KIND_PAYLOAD: begin
					payload_q <= cmd.payload_value;
				end
				KIND_END: begin
					status_q <= cmd.status;
				end
				default: begin
					status_q <= STATUS_OK;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			second_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				second_q <= !item_last;
			end else if (!result_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = valid_q;
	assign kind = kind_q;
	assign marker_bit = marker_q;
	assign payload_type = ptype_q;
	assign sequence_number = seq_q;
	assign time_stamp = ts_q;
	assign source_id = ssrc_q;
	assign payload_value = payload_q;
	assign status = status_q;
	assign last_of_run = last_q;

	a_second_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		second_q |-> (cmd_valid && cmd.emit_end))
		else $error("second item without end request");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && result_stall) |=> (valid_q && $stable(kind_q) && $stable(last_q)))
		else $error("output changed while stalled");

	a_first_of_two_not_end: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !last_q) |-> (kind_q != KIND_END))
		else $error("end item not last of its run");

endmodule

`default_nettype wire

FILE: rtl/rtp_header_parser.sv
// Top level of the RTP header parser: front end, command queue, back end.
// Depends on rhp_pkg, rhp_front, rhp_queue and rhp_back.
// Path: an accepted byte's command is registered in the queue entry, then its result in the output register.
// Throughput: one byte per cycle while the queue has a free entry; a final byte that also completes the header or
// carries payload yields two results, which the single output register sends one after the other.
// Reset (arst_n low, asynchronous): parse state, queue and output valid clear.
`timescale 1ns / 1ps
`default_nettype none

module rtp_header_parser (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// byte input transaction
	input  wire logic        byte_valid,
	output logic             byte_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        end_of_datagram,
	// result output transaction
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic [1:0]       kind,
	output logic             marker_bit,
	output logic [6:0]       payload_type,
	output logic [15:0]      sequence_number,
	output logic [31:0]      time_stamp,
	output logic [31:0]      source_id,
	output logic [7:0]       payload_value,
	output logic [1:0]       status,
	output logic             last_of_run
);
	import rhp_pkg::*;

	// Classified byte from the front end toward the queue
	logic push;
	cmd_t cmd_push;
	logic queue_full;

	// Head of the queue toward the back end
	logic queue_valid;
	cmd_t cmd_head;
	logic queue_pop;

	// Front end: parse the header layout and classify every byte.
	// Stall the byte input only when the queue has no free entry.
	rhp_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.byte_valid      (byte_valid),
		.byte_stall      (byte_stall),
		.data_byte       (data_byte),
		.end_of_datagram (end_of_datagram),
		.queue_full      (queue_full),
		.push            (push),
		.cmd             (cmd_push)
	);

	// Queue: decouple parsing from the result side so either can stall alone.
	rhp_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.cmd_in  (cmd_push),
		.full    (queue_full),
		.valid   (queue_valid),
		.cmd_out (cmd_head),
		.pop     (queue_pop)
	);

	// Back end: expand each command into its result transactions, advance
	// whenever the output register is empty or being drained.
	rhp_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd_valid       (queue_valid),
		.cmd             (cmd_head),
		.cmd_pop         (queue_pop),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.kind            (kind),
		.marker_bit      (marker_bit),
		.payload_type    (payload_type),
		.sequence_number (sequence_number),
		.time_stamp      (time_stamp),
		.source_id       (source_id),
		.payload_value   (payload_value),
		.status          (status),
		.last_of_run     (last_of_run)
	);

endmodule

`default_nettype wire
